>>> rtl/mfap_pkg.sv
// Shared types, codes and defaults for the max-flow augmenting-path engine.
package mfap_pkg;

	localparam int NODES_DEF     = 64;
	localparam int CAP_WIDTH_DEF = 32;
	localparam int NC_W          = 7;
	localparam int MAX_FLOW_W    = 38;
	localparam int PATH_W        = 16;
	localparam int IN_DATA_W     = 48;
	localparam int OUT_DATA_W    = 56;

	localparam logic [NC_W-1:0] NODE_COUNT_RST = 7'd64;

	localparam logic [1:0] FUNC_CLEAR   = 2'd0;
	localparam logic [1:0] FUNC_ADD     = 2'd1;
	localparam logic [1:0] FUNC_COMPUTE = 2'd2;

	typedef enum logic [4:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_BFS_INIT,
		ST_POP,
		ST_CUR,
		ST_SCAN,
		ST_DRAIN,
		ST_BN_INIT,
		ST_BN_PRED,
		ST_BN_RES,
		ST_BN_MIN,
		ST_AG_INIT,
		ST_AG_PRED,
		ST_AG_RES,
		ST_AG_SUB,
		ST_AG_REV,
		ST_AG_DONE,
		ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_SWEEP,
		OP_LOAD,
		OP_ADD_RD,
		OP_ADD_WR,
		OP_BFS_INIT,
		OP_POP,
		OP_CUR,
		OP_SCAN,
		OP_WALK_INIT,
		OP_EDGE_RD,
		OP_BN_MIN,
		OP_AG_SUB,
		OP_AG_REV,
		OP_AUG_DONE,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic queue_empty;
		logic scan_last;
		logic sink_seen;
		logic p_zero;
		logic out_free;
	} stat_t;

endpackage

>>> rtl/max_flow_augmenting_path.sv
// Top level of the max-flow engine: controller and datapath.
//
// The s_ channel takes one beat per operation: s_tuser selects clear (0), add edge (1)
// or compute (2); code 3 is dropped. Clear and add beats give no result; a compute beat
// gives one m_ beat holding the running flow total and the number of paths found.
// Node count is written on the cfg channel, which is always ready; the user must
// write it only while the block is idle, which the block does not enforce. An add-edge
// beat goes through accept, read and saturating write. A clear beat holds the block
// while all 2**(2*clog2(NODES)) matrix entries, 4096 at 64 nodes, are zeroed, one entry
// written per cycle through the single write port. After reset the same sweep runs, and
// s_tready stays low until it is done. A compute beat runs breadth-first searches
// in which each neighbour costs one read of the residual memory; each path found adds a
// bottleneck walk and an update of the entries along it. The result register is loaded
// once it is free.
// The result sits in an output register: the next beat is accepted while it waits, but
// a further compute holds its own result until m_tready has drained the register.
module max_flow_augmenting_path #(
	parameter int NODES     = mfap_pkg::NODES_DEF,
	parameter int CAP_WIDTH = mfap_pkg::CAP_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// from_node [5:0], to_node [11:6], capacity [43:12], zero [47:44]
	input  logic [mfap_pkg::IN_DATA_W-1:0]    s_tdata,
	// func [1:0]
	input  logic [1:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// max_flow [37:0], path_count [53:38], zero [55:54]
	output logic [mfap_pkg::OUT_DATA_W-1:0]   m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mfap_pkg::NC_W-1:0]         cfg_data
);

	mfap_pkg::cmd_t  cmd;
	mfap_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	mfap_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.stat     (stat),
		.cmd      (cmd)
	);

	mfap_dp #(
		.NODES     (NODES),
		.CAP_WIDTH (CAP_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

>>> rtl/mfap_dp.sv
// Datapath: residual matrix, search queue, predecessors, counters and result register.
module mfap_dp #(
	parameter int NODES     = mfap_pkg::NODES_DEF,
	parameter int CAP_WIDTH = mfap_pkg::CAP_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mfap_pkg::cmd_t                    cmd,
	output mfap_pkg::stat_t                   stat,
	input  logic                              cfg_valid,
	input  logic [mfap_pkg::NC_W-1:0]         cfg_data,
	input  logic [mfap_pkg::IN_DATA_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mfap_pkg::OUT_DATA_W-1:0]   m_tdata
);

	localparam int IW  = $clog2(NODES);
	localparam int NW  = IW + 1;
	localparam int AW  = 2 * IW;
	localparam int RW  = CAP_WIDTH + 2;
	localparam int FW  = CAP_WIDTH + 6;
	localparam int CIN = (CAP_WIDTH < 32) ? CAP_WIDTH : 32;

	logic [mfap_pkg::NC_W-1:0] node_count_q;
	logic [IW-1:0]             sink_q;
	logic [IW-1:0]             a_q, b_q;
	logic [RW-1:0]             cap_q;
	logic                      ok_q;

	logic [RW-1:0] res_mem [2**AW];
	logic [IW-1:0] pred_mem [NODES];
	logic [IW-1:0] queue_mem [NODES];

	logic [RW-1:0] res_rd;
	logic [IW-1:0] pred_rd;
	logic [IW-1:0] q_rd;

	logic [NODES-1:0]          seen_q;
	logic [NW-1:0]             head_q, tail_q;
	logic [IW-1:0]             cur_q, v_q, v_s1, w_q, p_q;
	logic                      vld_s1;
	logic [RW-1:0]             bott_q;
	logic                      first_q;
	logic [FW-1:0]             flow_q;
	logic [mfap_pkg::PATH_W-1:0] paths_q;
	logic [AW-1:0]             sweep_q;
	logic [mfap_pkg::MAX_FLOW_W-1:0] mflow_q;
	logic [mfap_pkg::PATH_W-1:0]     mpath_q;
	logic                      mvalid_q;

	logic [AW-1:0] rd_addr, wr_addr;
	logic          wr_en;
	logic [RW-1:0] wr_data;
	logic [RW-1:0] addend;
	logic [RW:0]   add_sum;
	logic [RW-1:0] add_sat;
	logic [FW:0]   flow_sum;
	logic          enqueue;
	int            nc_int, n_int;
	logic [IW-1:0] sink_nxt;
	logic          ok_nxt;

	always_comb begin
		nc_int = int'(node_count_q);
		if (nc_int < 2) begin
			n_int = 2;
		end else if (nc_int > NODES) begin
			n_int = NODES;
		end else begin
			n_int = nc_int;
		end
		sink_nxt = IW'(n_int - 1);
		ok_nxt = (int'(s_tdata[5:0]) < NODES) && (int'(s_tdata[11:6]) < NODES);
	end

	always_comb begin
		addend  = (cmd.op == mfap_pkg::OP_ADD_WR) ? cap_q : bott_q;
		add_sum = {1'b0, res_rd} + {1'b0, addend};
		add_sat = add_sum[RW] ? {RW{1'b1}} : add_sum[RW-1:0];
		flow_sum = {1'b0, flow_q} + (FW + 1)'(bott_q);
		enqueue = vld_s1 && !seen_q[v_s1] && (res_rd != '0);
	end

	always_comb begin
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		unique case (cmd.op)
			mfap_pkg::OP_SWEEP: begin
				wr_en   = 1'b1;
				wr_addr = sweep_q;
			end
			mfap_pkg::OP_ADD_RD: rd_addr = {a_q, b_q};
			mfap_pkg::OP_ADD_WR: begin
				wr_en   = ok_q;
				wr_addr = {a_q, b_q};
				wr_data = add_sat;
			end
			mfap_pkg::OP_SCAN: rd_addr = {cur_q, v_q};
			mfap_pkg::OP_EDGE_RD: rd_addr = {pred_rd, w_q};
			mfap_pkg::OP_AG_SUB: begin
				rd_addr = {w_q, p_q};
				wr_en   = 1'b1;
				wr_addr = {p_q, w_q};
				wr_data = res_rd - bott_q;
			end
			mfap_pkg::OP_AG_REV: begin
				wr_en   = 1'b1;
				wr_addr = {w_q, p_q};
				wr_data = add_sat;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		res_rd <= res_mem[rd_addr];
		if (wr_en) begin
			res_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		pred_rd <= pred_mem[w_q];
		q_rd    <= queue_mem[head_q[IW-1:0]];
		if (enqueue) begin
			pred_mem[v_s1] <= cur_q;
			queue_mem[tail_q[IW-1:0]] <= v_s1;
		end else if (cmd.op == mfap_pkg::OP_BFS_INIT) begin
			queue_mem[0] <= '0;
		end
	end

	// Payload and walk registers carry no reset.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			mfap_pkg::OP_LOAD: begin
				a_q    <= IW'(s_tdata[5:0]);
				b_q    <= IW'(s_tdata[11:6]);
				cap_q  <= RW'(s_tdata[12 +: CIN]);
				ok_q   <= ok_nxt;
				sink_q <= sink_nxt;
			end
			mfap_pkg::OP_CUR: begin
				cur_q <= q_rd;
				v_q   <= '0;
			end
			mfap_pkg::OP_SCAN: v_q <= v_q + 1'b1;
			mfap_pkg::OP_WALK_INIT: begin
				w_q     <= sink_q;
				first_q <= 1'b1;
			end
			mfap_pkg::OP_EDGE_RD: p_q <= pred_rd;
			mfap_pkg::OP_BN_MIN: begin
				if (first_q || (res_rd < bott_q)) begin
					bott_q <= res_rd;
				end
				first_q <= 1'b0;
				w_q     <= p_q;
			end
			mfap_pkg::OP_AG_REV: w_q <= p_q;
			mfap_pkg::OP_OUT: begin
				mflow_q <= mfap_pkg::MAX_FLOW_W'(flow_q);
				mpath_q <= paths_q;
			end
			default: begin
			end
		endcase
		v_s1 <= v_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= mfap_pkg::NODE_COUNT_RST;
			seen_q       <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			vld_s1       <= 1'b0;
			flow_q       <= '0;
			paths_q      <= '0;
			sweep_q      <= '0;
			mvalid_q     <= 1'b0;
		end else begin
			if (cfg_valid) begin
				node_count_q <= cfg_data;
			end
			vld_s1 <= (cmd.op == mfap_pkg::OP_SCAN);
			if (enqueue) begin
				seen_q[v_s1] <= 1'b1;
				tail_q       <= tail_q + 1'b1;
			end
			unique case (cmd.op)
				mfap_pkg::OP_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					flow_q  <= '0;
				end
				mfap_pkg::OP_LOAD: paths_q <= '0;
				mfap_pkg::OP_BFS_INIT: begin
					seen_q <= NODES'(1);
					head_q <= '0;
					tail_q <= NW'(1);
				end
				mfap_pkg::OP_POP: head_q <= head_q + 1'b1;
				mfap_pkg::OP_AUG_DONE: begin
					flow_q <= flow_sum[FW] ? {FW{1'b1}} : flow_sum[FW-1:0];
					if (paths_q != '1) begin
						paths_q <= paths_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (cmd.op == mfap_pkg::OP_OUT) begin
				mvalid_q <= 1'b1;
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.sweep_last  = &sweep_q;
		stat.queue_empty = (head_q == tail_q);
		stat.scan_last   = (v_q == sink_q);
		stat.sink_seen   = seen_q[sink_q];
		stat.p_zero      = (p_q == '0);
		stat.out_free    = !mvalid_q || m_tready;
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = {2'b00, mpath_q, mflow_q};

endmodule

>>> rtl/mfap_ctrl.sv
// Controller: sequences clearing, edge loads, breadth-first search and path augmentation.
module mfap_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [1:0]      s_tuser,
	input  mfap_pkg::stat_t stat,
	output mfap_pkg::cmd_t  cmd
);

	mfap_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mfap_pkg::ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = mfap_pkg::OP_NONE;
		s_tready = 1'b0;
		unique case (state_q)
			mfap_pkg::ST_SWEEP: begin
				cmd.op = mfap_pkg::OP_SWEEP;
				if (stat.sweep_last) begin
					state_d = mfap_pkg::ST_IDLE;
				end
			end
			mfap_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.op = mfap_pkg::OP_LOAD;
					unique case (s_tuser)
						mfap_pkg::FUNC_CLEAR:   state_d = mfap_pkg::ST_SWEEP;
						mfap_pkg::FUNC_ADD:     state_d = mfap_pkg::ST_ADD_RD;
						mfap_pkg::FUNC_COMPUTE: state_d = mfap_pkg::ST_BFS_INIT;
						default:                state_d = mfap_pkg::ST_IDLE;
					endcase
				end
			end
			mfap_pkg::ST_ADD_RD: begin
				cmd.op  = mfap_pkg::OP_ADD_RD;
				state_d = mfap_pkg::ST_ADD_WR;
			end
			mfap_pkg::ST_ADD_WR: begin
				cmd.op  = mfap_pkg::OP_ADD_WR;
				state_d = mfap_pkg::ST_IDLE;
			end
			mfap_pkg::ST_BFS_INIT: begin
				cmd.op  = mfap_pkg::OP_BFS_INIT;
				state_d = mfap_pkg::ST_POP;
			end
			mfap_pkg::ST_POP: begin
				if (!stat.queue_empty) begin
					cmd.op  = mfap_pkg::OP_POP;
					state_d = mfap_pkg::ST_CUR;
				end else if (stat.sink_seen) begin
					state_d = mfap_pkg::ST_BN_INIT;
				end else begin
					state_d = mfap_pkg::ST_OUT;
				end
			end
			mfap_pkg::ST_CUR: begin
				cmd.op  = mfap_pkg::OP_CUR;
				state_d = mfap_pkg::ST_SCAN;
			end
			mfap_pkg::ST_SCAN: begin
				cmd.op = mfap_pkg::OP_SCAN;
				if (stat.scan_last) begin
					state_d = mfap_pkg::ST_DRAIN;
				end
			end
			// The last neighbour is compared here before the queue is looked at again.
			mfap_pkg::ST_DRAIN: state_d = mfap_pkg::ST_POP;
			mfap_pkg::ST_BN_INIT: begin
				cmd.op  = mfap_pkg::OP_WALK_INIT;
				state_d = mfap_pkg::ST_BN_PRED;
			end
			mfap_pkg::ST_BN_PRED: state_d = mfap_pkg::ST_BN_RES;
			mfap_pkg::ST_BN_RES: begin
				cmd.op  = mfap_pkg::OP_EDGE_RD;
				state_d = mfap_pkg::ST_BN_MIN;
			end
			mfap_pkg::ST_BN_MIN: begin
				cmd.op  = mfap_pkg::OP_BN_MIN;
				state_d = stat.p_zero ? mfap_pkg::ST_AG_INIT : mfap_pkg::ST_BN_PRED;
			end
			mfap_pkg::ST_AG_INIT: begin
				cmd.op  = mfap_pkg::OP_WALK_INIT;
				state_d = mfap_pkg::ST_AG_PRED;
			end
			mfap_pkg::ST_AG_PRED: state_d = mfap_pkg::ST_AG_RES;
			mfap_pkg::ST_AG_RES: begin
				cmd.op  = mfap_pkg::OP_EDGE_RD;
				state_d = mfap_pkg::ST_AG_SUB;
			end
			mfap_pkg::ST_AG_SUB: begin
				cmd.op  = mfap_pkg::OP_AG_SUB;
				state_d = mfap_pkg::ST_AG_REV;
			end
			mfap_pkg::ST_AG_REV: begin
				cmd.op  = mfap_pkg::OP_AG_REV;
				state_d = stat.p_zero ? mfap_pkg::ST_AG_DONE : mfap_pkg::ST_AG_PRED;
			end
			mfap_pkg::ST_AG_DONE: begin
				cmd.op  = mfap_pkg::OP_AUG_DONE;
				state_d = mfap_pkg::ST_BFS_INIT;
			end
			mfap_pkg::ST_OUT: begin
				if (stat.out_free) begin
					cmd.op  = mfap_pkg::OP_OUT;
					state_d = mfap_pkg::ST_IDLE;
				end
			end
			default: state_d = mfap_pkg::ST_IDLE;
		endcase
	end

endmodule
